### rtl/core/per_process_io_anomaly_scorer_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the per-process I/O anomaly scorer
// Shared helpers for concurrent checks clocked on i_clk, reset by i_rst_n.
// ----------------------------------------------------------------------------
`ifndef PER_PROCESS_IO_ANOMALY_SCORER_UNIT_MACROS_SVH
`define PER_PROCESS_IO_ANOMALY_SCORER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPIAS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PPIAS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/ppias_pkg.sv
// ----------------------------------------------------------------------------
// ppias_pkg
// Types, constants and the extension list of the anomaly scorer.
// ----------------------------------------------------------------------------
package ppias_pkg;

    localparam int DEF_TRACKED_PROCESSES = 64;
    localparam int DEF_WINDOW_DEPTH      = 64;

    localparam logic [6:0] W_RATE    = 7'd30;
    localparam logic [6:0] W_ENTROPY = 7'd40;
    localparam logic [6:0] W_EXT     = 7'd20;
    localparam logic [6:0] W_DELETE  = 7'd10;
    localparam logic [6:0] SCORE_CAP = 7'd100;

    localparam logic signed [44:0] MS_PER_SEC = 45'sd1000;

    localparam logic [1:0] KIND_RENAME = 2'd1;
    localparam logic [1:0] KIND_UNLINK = 2'd2;
    localparam logic       REQ_CLEANUP = 1'b1;

    localparam int EXT_NAMES = 14;

    localparam logic [95:0] EXT_NAME [EXT_NAMES] = '{
        96'("encrypted"), 96'("locked"), 96'("cry"), 96'("crypt"), 96'("locky"),
        96'("cerber"), 96'("zepto"), 96'("thor"), 96'("aaa"), 96'("zzz"),
        96'("micro"), 96'("enc"), 96'("crypted"), 96'("cryptolocker")
    };
    localparam int EXT_LEN [EXT_NAMES] = '{9, 6, 3, 5, 5, 6, 5, 4, 3, 3, 5, 3, 7, 12};

    typedef enum logic [2:0] {
        REG_ENT_LIMIT         = 3'd0,
        REG_RATE_LIMIT        = 3'd1,
        REG_RATE_WINDOW_MS    = 3'd2,
        REG_UNLINK_WINDOW_SEC = 3'd3,
        REG_STALE_AGE_SEC     = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [11:0] ent_limit;
        logic [6:0]  rate_limit;
        logic [15:0] rate_window_ms;
        logic [7:0]  unlink_window_sec;
        logic [31:0] stale_age_sec;
    } t_cfg;

    typedef struct packed {
        logic        req_type;
        logic [31:0] pid;
        logic [31:0] time_sec;
        logic [9:0]  time_msec;
        logic [1:0]  event_kind;
        logic [11:0] entropy;
        logic        has_new_path;
        logic [4:0]  ext_len;
        logic [63:0] ext_lo;
        logic [31:0] ext_hi;
    } t_req;

    typedef struct packed {
        logic [6:0] score;
        logic       suspicious;
        logic       rate_hit;
        logic       entropy_hit;
        logic       extension_hit;
        logic       delete_hit;
        logic [6:0] recent_ops;
        logic [6:0] active_records;
    } t_res;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SEARCH, ST_SEARCH_END, ST_PICK, ST_UPDATE, ST_SCAN, ST_SCAN_END, ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic srch_step;
        logic pick;
        logic update;
        logic scan_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic srch_last;
        logic scan_last;
        logic cleanup;
    } t_stat;

    function automatic logic ext_listed(logic [4:0] len, logic [63:0] lo, logic [31:0] hi);
        logic [95:0] b;
        logic        hit;
        logic        same;
        int          j;
        b   = {hi, lo};
        hit = 1'b0;
        for (int n = 0; n < EXT_NAMES; n++) begin
            same = (32'(len) == EXT_LEN[n]);
            for (int k = 0; k < 12; k++) begin
                if (k < EXT_LEN[n]) begin
                    j = EXT_LEN[n] - 1 - k;
                    if (b[8*k +: 8] != EXT_NAME[n][8*j +: 8]) begin
                        same = 1'b0;
                    end
                end
            end
            if (same) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

### rtl/core/ppias_regs.sv
// ----------------------------------------------------------------------------
// ppias_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module ppias_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output ppias_pkg::t_cfg   o_cfg
);
    import ppias_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx    = t_reg_idx'(paddr[4:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ent_limit         <= 12'd1920;
            r_cfg.rate_limit        <= 7'd50;
            r_cfg.rate_window_ms    <= 16'd100;
            r_cfg.unlink_window_sec <= 8'd5;
            r_cfg.stale_age_sec     <= 32'd60;
        end else if (wr) begin
            unique case (idx)
                REG_ENT_LIMIT:         r_cfg.ent_limit         <= pwdata[11:0];
                REG_RATE_LIMIT:        r_cfg.rate_limit        <= pwdata[6:0];
                REG_RATE_WINDOW_MS:    r_cfg.rate_window_ms    <= pwdata[15:0];
                REG_UNLINK_WINDOW_SEC: r_cfg.unlink_window_sec <= pwdata[7:0];
                REG_STALE_AGE_SEC:     r_cfg.stale_age_sec     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_ENT_LIMIT:         prdata = 32'(r_cfg.ent_limit);
            REG_RATE_LIMIT:        prdata = 32'(r_cfg.rate_limit);
            REG_RATE_WINDOW_MS:    prdata = 32'(r_cfg.rate_window_ms);
            REG_UNLINK_WINDOW_SEC: prdata = 32'(r_cfg.unlink_window_sec);
            REG_STALE_AGE_SEC:     prdata = r_cfg.stale_age_sec;
            default:               prdata = 32'd0;
        endcase
    end

endmodule

### rtl/core/ppias_ctrl.sv
// ----------------------------------------------------------------------------
// ppias_ctrl
// Sequencer for table search, slot update and window scan.
// ----------------------------------------------------------------------------
module ppias_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  ppias_pkg::t_stat i_stat,
    output ppias_pkg::t_cmd  o_cmd
);
    import ppias_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                o_cmd.srch_step = 1'b1;
                if (i_stat.srch_last) begin
                    n_state = ST_SEARCH_END;
                end
            end
            ST_SEARCH_END: begin
                n_state = i_stat.cleanup ? ST_DONE : ST_PICK;
            end
            ST_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

### rtl/core/ppias_dp.sv
// ----------------------------------------------------------------------------
// ppias_dp
// Record table, event-time memory and scoring datapath.
// ----------------------------------------------------------------------------
module ppias_dp #(
    parameter int TRACKED_PROCESSES = ppias_pkg::DEF_TRACKED_PROCESSES,
    parameter int WINDOW_DEPTH      = ppias_pkg::DEF_WINDOW_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ppias_pkg::t_req  i_req,
    input  ppias_pkg::t_cfg  i_cfg,
    input  ppias_pkg::t_cmd  i_cmd,
    output ppias_pkg::t_stat o_stat,
    output ppias_pkg::t_res  o_res,
    output logic             o_strobe
);
    import ppias_pkg::*;

    localparam int N   = TRACKED_PROCESSES;
    localparam int W   = WINDOW_DEPTH;
    localparam int SW  = $clog2(N);
    localparam int WW  = $clog2(W);
    localparam int FW  = $clog2(W + 1);
    localparam int CW  = $clog2((N > W) ? N : W);
    localparam int EAW = $clog2(N * W);
    localparam int TW  = $clog2(N + 1);

    typedef struct packed {
        logic [31:0]   pid;
        logic [31:0]   last;
        logic [WW-1:0] head;
        logic [FW-1:0] fill;
        logic          seen;
        logic [31:0]   esec;
    } t_rec;

    t_rec        r_rec_mem [N];
    t_rec        r_rec_q;
    logic [41:0] r_ev_mem [N*W];
    logic [41:0] r_ev_q;

    t_req              r_in;
    logic [N-1:0]      r_valid;
    logic [TW-1:0]     r_total;
    logic [CW-1:0]     r_ai;
    logic [CW-1:0]     r_ci;
    logic              r_cv;
    logic              r_sv;
    logic              r_mfound;
    logic              r_ffound;
    logic [SW-1:0]     r_midx;
    logic [SW-1:0]     r_fidx;
    logic [SW-1:0]     r_oidx;
    logic signed [32:0] r_oage;
    logic [SW-1:0]     r_slot;
    logic              r_new;
    logic [FW-1:0]     r_fill;
    logic [FW-1:0]     r_ops;
    logic              r_ehit;
    logic              r_xhit;
    logic              r_dhit;
    t_res              r_res;
    logic              r_strobe;

    logic [SW-1:0]      slot_sel;
    logic [SW-1:0]      rec_raddr;
    logic [SW-1:0]      cidx;
    logic               cv_valid;
    logic signed [32:0] age;
    logic               cleanup;
    logic [WW-1:0]      head0;
    logic [FW-1:0]      fill0;
    logic [WW-1:0]      nhead;
    logic [FW-1:0]      nfill;
    logic               ehit;
    logic               seen1;
    logic [31:0]        sec1;
    logic signed [32:0] dd;
    logic               dhit;
    logic               xhit;
    logic [EAW-1:0]     ev_waddr;
    logic [EAW-1:0]     ev_raddr;
    logic signed [32:0] sd;
    logic signed [10:0] md;
    logic signed [44:0] dms;
    logic               inwin;
    logic [6:0]         score_sum;

    assign cleanup   = (r_in.req_type == REQ_CLEANUP);
    assign slot_sel  = r_mfound ? r_midx : (r_ffound ? r_fidx : r_oidx);
    assign rec_raddr = i_cmd.pick ? slot_sel : r_ai[SW-1:0];
    assign cidx      = r_ci[SW-1:0];
    assign cv_valid  = r_valid[cidx];
    assign age       = $signed({1'b0, r_in.time_sec}) - $signed({1'b0, r_rec_q.last});

    assign head0 = r_new ? '0 : r_rec_q.head;
    assign fill0 = r_new ? '0 : r_rec_q.fill;
    assign nhead = (head0 == WW'(W - 1)) ? '0 : head0 + WW'(1);
    assign nfill = (fill0 == FW'(W)) ? fill0 : fill0 + FW'(1);
    assign ehit  = (r_in.entropy >= i_cfg.ent_limit);
    assign seen1 = ehit || (!r_new && r_rec_q.seen);
    assign sec1  = ehit ? r_in.time_sec : (r_new ? 32'd0 : r_rec_q.esec);
    assign dd    = $signed({1'b0, r_in.time_sec}) - $signed({1'b0, sec1});
    assign dhit  = (r_in.event_kind == KIND_UNLINK) && seen1 && (dd >= 0)
                   && (dd <= $signed({25'd0, i_cfg.unlink_window_sec}));
    assign xhit  = (r_in.event_kind == KIND_RENAME) && r_in.has_new_path
                   && ext_listed(r_in.ext_len, r_in.ext_lo, r_in.ext_hi);

    assign ev_waddr = EAW'(r_slot) * EAW'(W) + EAW'(head0);
    assign ev_raddr = EAW'(r_slot) * EAW'(W) + EAW'(r_ai[WW-1:0]);

    assign sd    = $signed({1'b0, r_in.time_sec}) - $signed({1'b0, r_ev_q[41:10]});
    assign md    = $signed({1'b0, r_in.time_msec}) - $signed({1'b0, r_ev_q[9:0]});
    assign dms   = 45'(sd) * MS_PER_SEC + 45'(md);
    assign inwin = (dms >= 0) && (dms <= $signed({29'd0, i_cfg.rate_window_ms}));

    assign score_sum = (r_ehit ? W_ENTROPY : 7'd0) + (r_xhit ? W_EXT : 7'd0)
                     + (r_dhit ? W_DELETE : 7'd0)
                     + ((32'(r_ops) > 32'(i_cfg.rate_limit)) ? W_RATE : 7'd0);

    assign o_stat.srch_last = (r_ai == CW'(N - 1));
    assign o_stat.scan_last = (r_ai == CW'(r_fill - FW'(1)));
    assign o_stat.cleanup   = cleanup;
    assign o_res            = r_res;
    assign o_strobe         = r_strobe;

    always_ff @(posedge i_clk) begin
        r_rec_q <= r_rec_mem[rec_raddr];
        r_ev_q  <= r_ev_mem[ev_raddr];
        if (i_cmd.update) begin
            r_rec_mem[r_slot] <= '{pid: r_in.pid, last: r_in.time_sec, head: nhead,
                                   fill: nfill, seen: seen1, esec: sec1};
            r_ev_mem[ev_waddr] <= {r_in.time_sec, r_in.time_msec};
        end
    end

    always_ff @(posedge i_clk) begin
        r_ci <= r_ai;
        if (i_cmd.load) begin
            r_in     <= i_req;
            r_ai     <= '0;
            r_mfound <= 1'b0;
            r_ffound <= 1'b0;
            r_oidx   <= '0;
            r_oage   <= '0;
            r_ops    <= '0;
            r_ehit   <= 1'b0;
            r_xhit   <= 1'b0;
            r_dhit   <= 1'b0;
        end
        if (i_cmd.srch_step || i_cmd.scan_step) begin
            r_ai <= r_ai + CW'(1);
        end
        if (r_cv && !cleanup) begin
            if (cv_valid && (r_rec_q.pid == r_in.pid) && !r_mfound) begin
                r_mfound <= 1'b1;
                r_midx   <= cidx;
            end
            if (!cv_valid && !r_ffound) begin
                r_ffound <= 1'b1;
                r_fidx   <= cidx;
            end
            if (cv_valid && (age > r_oage)) begin
                r_oage <= age;
                r_oidx <= cidx;
            end
        end
        if (i_cmd.pick) begin
            r_slot <= slot_sel;
            r_new  <= !r_mfound;
        end
        if (i_cmd.update) begin
            r_ai   <= '0;
            r_fill <= nfill;
            r_ehit <= ehit;
            r_xhit <= xhit;
            r_dhit <= dhit;
        end
        if (r_sv && inwin) begin
            r_ops <= r_ops + FW'(1);
        end
        if (i_cmd.finish) begin
            r_res.score          <= (score_sum > SCORE_CAP) ? SCORE_CAP : score_sum;
            r_res.suspicious     <= (score_sum != 7'd0);
            r_res.rate_hit       <= (32'(r_ops) > 32'(i_cfg.rate_limit));
            r_res.entropy_hit    <= r_ehit;
            r_res.extension_hit  <= r_xhit;
            r_res.delete_hit     <= r_dhit;
            r_res.recent_ops     <= 7'(r_ops);
            r_res.active_records <= 7'(r_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_total  <= '0;
            r_cv     <= 1'b0;
            r_sv     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_cv     <= i_cmd.srch_step;
            r_sv     <= i_cmd.scan_step;
            r_strobe <= i_cmd.finish;
            if (r_cv && cleanup && cv_valid
                && (age >= $signed({1'b0, i_cfg.stale_age_sec}))) begin
                r_valid[cidx] <= 1'b0;
                if (r_total != '0) begin
                    r_total <= r_total - TW'(1);
                end
            end
            if (i_cmd.pick) begin
                r_valid[slot_sel] <= 1'b1;
                if (!r_mfound && r_ffound) begin
                    r_total <= r_total + TW'(1);
                end
            end
        end
    end

endmodule

### rtl/core/per_process_io_anomaly_scorer_unit.sv
// ----------------------------------------------------------------------------
// per_process_io_anomaly_scorer_unit
// Scores file-system events per process against fixed-weight rules.
//
//   Channel   Handshake                 Payload
//   request   start, busy               i_req (one word per start)
//   result    o_strobe (one cycle)      o_res
//   config    psel/penable/pwrite/...   pwdata, prdata
//
// An event runs the table search over every record, picks and updates a
// slot, then scans the stored times of that record; a cleanup runs only
// the search. The table search reads one record per cycle and the window
// scan reads one event time per cycle from the event memory. The result
// strobe comes in the same cycle that busy falls. Reset is synchronous
// and clears the valid bits and record count at once.
// ----------------------------------------------------------------------------
`include "per_process_io_anomaly_scorer_unit_macros.svh"

module per_process_io_anomaly_scorer_unit #(
    parameter int TRACKED_PROCESSES = ppias_pkg::DEF_TRACKED_PROCESSES,
    parameter int WINDOW_DEPTH      = ppias_pkg::DEF_WINDOW_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  ppias_pkg::t_req  i_req,
    output logic             o_strobe,
    output ppias_pkg::t_res  o_res,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ppias_pkg::*;

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;

    ppias_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ppias_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    ppias_dp #(
        .TRACKED_PROCESSES (TRACKED_PROCESSES),
        .WINDOW_DEPTH      (WINDOW_DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cfg    (cfg),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_res    (o_res),
        .o_strobe (o_strobe)
    );

    `PPIAS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
    `PPIAS_ASSERT_NOW(a_strobe_idle, o_strobe, !busy, "result strobe while busy")
    `PPIAS_ASSERT_NEXT(a_strobe_single, o_strobe, !o_strobe, "result strobe longer than a cycle")
    `PPIAS_ASSERT_NOW(a_cleanup_quiet, o_strobe && (cmd == '0) && !o_res.suspicious, o_res.score == 7'd0, "zero score mismatch")

endmodule
